// ===== rtl/core/npr_pkg.sv =====
// ----------------------------------------------------------------------------
// npr_pkg: shared definitions of the no-repeat random picker
// Field widths, the default history depth and the result status codes.
// ----------------------------------------------------------------------------
package npr_pkg;

  // Default number of hashes kept in the recent-play history.
  localparam int HISTORY_DEPTH_DEF = 128;

  // Widths of the word fields.
  localparam int HASH_W   = 32;
  localparam int RAND_W   = 32;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_FRESH = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_AGAIN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd2;

  // Input word kinds.
  localparam logic KIND_CAND = 1'b0;
  localparam logic KIND_END  = 1'b1;

endpackage

// ===== rtl/core/no_repeat_random_picker.sv =====
// ----------------------------------------------------------------------------
// no_repeat_random_picker: random pick over a scan, avoiding recent picks
//
// Input words arrive on the in_ channel (valid/ready). A candidate word
// (kind 0) carries a hash and two random words and produces no result. An
// end-of-scan word (kind 1) produces one result word on the out_ channel:
// the status, the chosen hash and the two counts of the scan.
// A candidate is held by the history scan, one entry per cycle through the
// memory read port after setup and read latency, followed by one or two
// 32-step remainder runs on the shared restoring divider: two when its hash
// is fresh, one when it is in the history. The history holds at most
// HISTORY_DEPTH entries. An end-of-scan word with a fresh pick takes the
// history search and write that record the chosen hash; after a history
// clear it takes only the write.
// in_ready is high only while the sequencer is idle.
// Reset empties the history and clears the counters and both choices.
// A finished result sits in the output register until taken. Meanwhile
// candidates and one more end-of-scan word are still taken; that word then
// holds the input until the receiver frees the output register.
// ----------------------------------------------------------------------------
module no_repeat_random_picker
  import npr_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic [HASH_W-1:0]   in_candidate_hash,
  input  logic [RAND_W-1:0]   in_rand_fresh,
  input  logic [RAND_W-1:0]   in_rand_any,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [HASH_W-1:0]   out_chosen_hash,
  output logic [COUNT_W-1:0]  out_total_count,
  output logic [COUNT_W-1:0]  out_available_count
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = FW + 1;
  localparam int DCW = $clog2(RAND_W);

  localparam logic [AW-1:0] ADDR_LAST = AW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(HISTORY_DEPTH);
  localparam logic [SW-1:0] DEPTH_S   = SW'(HISTORY_DEPTH);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(RAND_W - 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_EOS    = 3'd4;
  localparam logic [2:0] ST_WRITE  = 3'd5;

  // Saturating count increment.
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Control registers.
  logic [2:0]         state_r, state_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic [COUNT_W-1:0] fresh_r, fresh_nxt;
  logic [HASH_W-1:0]  fresh_choice_r, fresh_choice_nxt;
  logic [HASH_W-1:0]  any_choice_r, any_choice_nxt;
  logic               rec_r, rec_nxt;
  logic               div_fresh_r, div_fresh_nxt;
  logic               hit_r, hit_nxt;
  logic [FW-1:0]      issue_r, issue_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [DCW-1:0]     dcnt_r, dcnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [HASH_W-1:0]   key_r, key_nxt;
  logic [RAND_W-1:0]   rf_r, rf_nxt;
  logic [RAND_W-1:0]   ra_r, ra_nxt;
  logic [RAND_W-1:0]   num_r, num_nxt;
  logic [COUNT_W-1:0]  den_r, den_nxt;
  logic [COUNT_W-1:0]  rem_r, rem_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [HASH_W-1:0]   out_hash_r, out_hash_nxt;
  logic [COUNT_W-1:0]  out_total_r, out_total_nxt;
  logic [COUNT_W-1:0]  out_avail_r, out_avail_nxt;

  // History memory.
  logic [HASH_W-1:0] hist_mem [HISTORY_DEPTH];
  logic [HASH_W-1:0] rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;

  // Helpers.
  logic              in_acc;
  logic              hit_now;
  logic              search_done;
  logic [SW-1:0]     tail_sum;
  logic [AW-1:0]     tail_addr;
  logic [AW-1:0]     head_inc;
  logic [COUNT_W:0]  div_trial;
  logic              div_ge;
  logic [COUNT_W-1:0] div_rem;
  logic              out_free;
  logic [COUNT_W-1:0] fresh_inc;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_status          = out_status_r;
  assign out_chosen_hash     = out_hash_r;
  assign out_total_count     = out_total_r;
  assign out_available_count = out_avail_r;
  assign out_free  = !out_valid_r || out_ready;

  // Search compare on the registered read data.
  assign hit_now     = rd_vld_r && (rd_data_r == key_r);
  assign search_done = hit_now || ((issue_r == fill_r) && !rd_vld_r);

  // Slot after the newest entry, and the wrapped successor of the head.
  assign tail_sum  = SW'(head_r) + SW'(fill_r);
  assign tail_addr = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign head_inc  = (head_r == ADDR_LAST) ? '0 : head_r + 1'b1;

  // One restoring remainder step.
  assign div_trial = {rem_r, num_r[RAND_W-1]};
  assign div_ge    = (div_trial >= {1'b0, den_r});
  assign div_rem   = div_ge ? COUNT_W'(div_trial - {1'b0, den_r}) : div_trial[COUNT_W-1:0];

  assign fresh_inc = sat_inc(fresh_r);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt        = state_r;
    fill_nxt         = fill_r;
    head_nxt         = head_r;
    total_nxt        = total_r;
    fresh_nxt        = fresh_r;
    fresh_choice_nxt = fresh_choice_r;
    any_choice_nxt   = any_choice_r;
    rec_nxt          = rec_r;
    div_fresh_nxt    = div_fresh_r;
    hit_nxt          = hit_r;
    issue_nxt        = issue_r;
    addr_nxt         = addr_r;
    rd_vld_nxt       = 1'b0;
    dcnt_nxt         = dcnt_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    key_nxt          = key_r;
    rf_nxt           = rf_r;
    ra_nxt           = ra_r;
    num_nxt          = num_r;
    den_nxt          = den_r;
    rem_nxt          = rem_r;
    out_status_nxt   = out_status_r;
    out_hash_nxt     = out_hash_r;
    out_total_nxt    = out_total_r;
    out_avail_nxt    = out_avail_r;
    mem_we           = 1'b0;
    mem_wa           = tail_addr;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_CAND) begin
            key_nxt   = in_candidate_hash;
            rf_nxt    = in_rand_fresh;
            ra_nxt    = in_rand_any;
            total_nxt = sat_inc(total_r);
            rec_nxt   = 1'b0;
            state_nxt = ST_SETUP;
          end else begin
            state_nxt = ST_EOS;
          end
        end
      end

      // Start a history search for key_r.
      ST_SETUP: begin
        issue_nxt = '0;
        addr_nxt  = head_r;
        state_nxt = ST_SEARCH;
      end

      // One read issued and one compare made per cycle.
      ST_SEARCH: begin
        if (search_done) begin
          hit_nxt = hit_now;
          if (rec_r) begin
            state_nxt = hit_now ? ST_IDLE : ST_WRITE;
          end else begin
            if (!hit_now) begin
              fresh_nxt = fresh_inc;
            end
            div_fresh_nxt = 1'b0;
            num_nxt       = ra_r;
            den_nxt       = total_r;
            rem_nxt       = '0;
            dcnt_nxt      = '0;
            state_nxt     = ST_DIV;
          end
        end else if (issue_r != fill_r) begin
          rd_vld_nxt = 1'b1;
          issue_nxt  = issue_r + 1'b1;
          addr_nxt   = (addr_r == ADDR_LAST) ? '0 : addr_r + 1'b1;
        end
      end

      // Remainder of a random word by a sampler count, one bit per cycle.
      ST_DIV: begin
        rem_nxt  = div_rem;
        num_nxt  = {num_r[RAND_W-2:0], 1'b0};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DIV_LAST) begin
          if (div_fresh_r) begin
            if (div_rem == '0) begin
              fresh_choice_nxt = key_r;
            end
            state_nxt = ST_IDLE;
          end else begin
            if (div_rem == '0) begin
              any_choice_nxt = key_r;
            end
            if (!hit_r) begin
              div_fresh_nxt = 1'b1;
              num_nxt       = rf_r;
              den_nxt       = fresh_r;
              rem_nxt       = '0;
              dcnt_nxt      = '0;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end

      // Deliver the pick once the output register is free, reset the scan and record the pick.
      ST_EOS: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_total_nxt    = total_r;
          out_avail_nxt    = fresh_r;
          total_nxt        = '0;
          fresh_nxt        = '0;
          fresh_choice_nxt = '0;
          any_choice_nxt   = '0;
          rec_nxt          = 1'b1;
          if (fresh_r != '0) begin
            out_status_nxt = STATUS_FRESH;
            out_hash_nxt   = fresh_choice_r;
            key_nxt        = fresh_choice_r;
            state_nxt      = (fresh_choice_r == '0) ? ST_IDLE : ST_SETUP;
          end else if (total_r != '0) begin
            out_status_nxt = STATUS_AGAIN;
            out_hash_nxt   = any_choice_r;
            key_nxt        = any_choice_r;
            fill_nxt       = '0;
            state_nxt      = (any_choice_r == '0) ? ST_IDLE : ST_WRITE;
          end else begin
            out_status_nxt = STATUS_NONE;
            out_hash_nxt   = '0;
            state_nxt      = ST_IDLE;
          end
        end
      end

      // Append the key; a full history drops its oldest entry.
      ST_WRITE: begin
        mem_we = 1'b1;
        if (fill_r == FILL_FULL) begin
          mem_wa   = head_r;
          head_nxt = head_inc;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      fill_r         <= '0;
      head_r         <= '0;
      total_r        <= '0;
      fresh_r        <= '0;
      fresh_choice_r <= '0;
      any_choice_r   <= '0;
      rec_r          <= 1'b0;
      div_fresh_r    <= 1'b0;
      hit_r          <= 1'b0;
      issue_r        <= '0;
      addr_r         <= '0;
      rd_vld_r       <= 1'b0;
      dcnt_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      fill_r         <= fill_nxt;
      head_r         <= head_nxt;
      total_r        <= total_nxt;
      fresh_r        <= fresh_nxt;
      fresh_choice_r <= fresh_choice_nxt;
      any_choice_r   <= any_choice_nxt;
      rec_r          <= rec_nxt;
      div_fresh_r    <= div_fresh_nxt;
      hit_r          <= hit_nxt;
      issue_r        <= issue_nxt;
      addr_r         <= addr_nxt;
      rd_vld_r       <= rd_vld_nxt;
      dcnt_r         <= dcnt_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    rf_r         <= rf_nxt;
    ra_r         <= ra_nxt;
    num_r        <= num_nxt;
    den_r        <= den_nxt;
    rem_r        <= rem_nxt;
    out_status_r <= out_status_nxt;
    out_hash_r   <= out_hash_nxt;
    out_total_r  <= out_total_nxt;
    out_avail_r  <= out_avail_nxt;
  end

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_wa] <= key_r;
    end
    rd_data_r <= hist_mem[addr_r];
  end

endmodule

// ===== rtl/core/npr_checker.sv =====
// ----------------------------------------------------------------------------
// npr_checker: port-level checks of the no-repeat random picker
// Watches the two channels and checks the result words against the scan.
// ----------------------------------------------------------------------------
module npr_checker
  import npr_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_kind,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [HASH_W-1:0]   out_chosen_hash,
  input logic [COUNT_W-1:0]  out_total_count,
  input logic [COUNT_W-1:0]  out_available_count
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_chosen_hash) && $stable(out_total_count) &&
      $stable(out_available_count))
    else $error("result word changed while stalled");

  // A candidate word never produces a result.
  a_cand_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_CAND) |=> !$rose(out_valid))
    else $error("result appeared after a candidate word");

  // An empty scan reports nothing, with zero hash and counts.
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_NONE) |->
      (out_chosen_hash == '0) && (out_total_count == '0) &&
      (out_available_count == '0))
    else $error("nothing-found result with nonzero fields");

  // A pick after clearing the history means no fresh candidate but some candidate.
  a_again: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_AGAIN) |->
      (out_available_count == '0) && (out_total_count != '0))
    else $error("history-cleared pick with inconsistent counts");

  // A fresh pick needs fresh candidates, never more than all candidates.
  a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_FRESH) |->
      (out_available_count != '0) && (out_available_count <= out_total_count))
    else $error("fresh pick with inconsistent counts");

endmodule

bind no_repeat_random_picker npr_checker u_npr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_kind             (in_kind),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_chosen_hash     (out_chosen_hash),
  .out_total_count     (out_total_count),
  .out_available_count (out_available_count)
);

// ===== dv/npr_pick_checker.sv =====
// ----------------------------------------------------------------------------
// npr_pick_checker: result checker for the no-repeat random picker
// Watches both channels. Each accepted input word updates a private model of
// the history and the two samplers; each end-of-scan word queues the pick it
// should produce. Each accepted result word is compared field by field with
// the oldest queued pick.
// ----------------------------------------------------------------------------
module npr_pick_checker
  import npr_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_kind,
  input  logic [HASH_W-1:0]   in_candidate_hash,
  input  logic [RAND_W-1:0]   in_rand_fresh,
  input  logic [RAND_W-1:0]   in_rand_any,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [HASH_W-1:0]   out_chosen_hash,
  input  logic [COUNT_W-1:0]  out_total_count,
  input  logic [COUNT_W-1:0]  out_available_count,
  output int                  mismatches,
  output int                  picks_pending
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HASH_W-1:0]   hash;
    logic [COUNT_W-1:0]  total;
    logic [COUNT_W-1:0]  fresh;
  } pick_t;

  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

  // Model state: recent-play history, scan counters and sampler choices.
  logic [HASH_W-1:0]  played_hashes [HISTORY_DEPTH];
  int unsigned        played_fill;
  logic [COUNT_W-1:0] scan_total;
  logic [COUNT_W-1:0] scan_fresh;
  logic [HASH_W-1:0]  fresh_pick;
  logic [HASH_W-1:0]  any_pick;

  pick_t picks_due [$];
  int    fail_count   = 0;
  int    results_seen = 0;

  function automatic bit was_played(logic [HASH_W-1:0] h);
    for (int i = 0; i < played_fill; i++) begin
      if (played_hashes[i] == h) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Record a pick; zero and already present hashes leave the history alone.
  function automatic void log_play(logic [HASH_W-1:0] h);
    if (h == '0 || was_played(h)) return;
    if (played_fill == HISTORY_DEPTH) begin
      for (int i = 1; i < HISTORY_DEPTH; i++) played_hashes[i-1] = played_hashes[i];
      played_fill = HISTORY_DEPTH - 1;
    end
    played_hashes[played_fill] = h;
    played_fill++;
  endfunction

  function automatic logic [COUNT_W-1:0] bump_count(logic [COUNT_W-1:0] c);
    return (c == COUNT_TOP) ? c : c + 1'b1;
  endfunction

  // Both reservoir samplers see a candidate; only the fresh one checks history.
  function automatic void offer_candidate(logic [HASH_W-1:0] h, logic [RAND_W-1:0] rf,
                                          logic [RAND_W-1:0] ra);
    scan_total = bump_count(scan_total);
    if (ra % 32'(scan_total) == 0) any_pick = h;
    if (!was_played(h)) begin
      scan_fresh = bump_count(scan_fresh);
      if (rf % 32'(scan_fresh) == 0) fresh_pick = h;
    end
  endfunction

  // End of scan: fresh pick first, else clear the history and take any pick.
  function automatic pick_t close_scan();
    pick_t p;
    p.total = scan_total;
    p.fresh = scan_fresh;
    if (scan_fresh != 0) begin
      p.status = STATUS_FRESH;
      p.hash   = fresh_pick;
      log_play(fresh_pick);
    end else if (scan_total != 0) begin
      p.status    = STATUS_AGAIN;
      p.hash      = any_pick;
      played_fill = 0;
      log_play(any_pick);
    end else begin
      p.status = STATUS_NONE;
      p.hash   = '0;
    end
    scan_total = '0;
    scan_fresh = '0;
    fresh_pick = '0;
    any_pick   = '0;
    return p;
  endfunction

  task automatic flag_mismatch(string what, logic [HASH_W-1:0] got, logic [HASH_W-1:0] want);
    $display("%0t: result %0d %s: got %0h, expected %0h", $time, results_seen, what, got, want);
    fail_count++;
  endtask

  // Results are checked before inputs: a word taken at this edge cannot
  // have produced a result at the same edge.
  always @(posedge clk) begin : watch
    pick_t got;
    pick_t want;
    if (!rst_n) begin
      played_fill = 0;
      scan_total  = '0;
      scan_fresh  = '0;
      fresh_pick  = '0;
      any_pick    = '0;
      picks_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_status, out_chosen_hash, out_total_count, out_available_count};
        results_seen++;
        if (picks_due.size() == 0) begin
          flag_mismatch("result word with no pick pending", got.hash, '0);
        end else begin
          want = picks_due.pop_front();
          if (got.status !== want.status)
            flag_mismatch("status", HASH_W'(got.status), HASH_W'(want.status));
          if (got.hash !== want.hash) flag_mismatch("chosen hash", got.hash, want.hash);
          if (got.total !== want.total)
            flag_mismatch("total count", HASH_W'(got.total), HASH_W'(want.total));
          if (got.fresh !== want.fresh)
            flag_mismatch("available count", HASH_W'(got.fresh), HASH_W'(want.fresh));
        end
      end
      if (in_valid && in_ready) begin
        if (in_kind == KIND_END) begin
          picks_due.push_back(close_scan());
        end else begin
          offer_candidate(in_candidate_hash, in_rand_fresh, in_rand_any);
        end
      end
    end
    mismatches    <= fail_count;
    picks_pending <= picks_due.size();
  end

endmodule

// ===== dv/no_repeat_random_picker_tb.sv =====
// ----------------------------------------------------------------------------
// no_repeat_random_picker_tb: top of the picker testbench
// Drives scans of candidate words closed by end-of-scan words: a directed
// opening, a phase of fresh hashes that fills and rolls the history, a phase
// with no idling, a long receiver hold-off, and a phase of reused hashes that
// forces history clears.
// The checker beside the block predicts every pick; this module decides the
// verdict.
// ----------------------------------------------------------------------------
module no_repeat_random_picker_tb;
  import npr_pkg::*;

  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int STALL_LIMIT     = 20000;
  localparam int DRAIN_CYCLES    = 400;

  localparam logic [HASH_W-1:0] HASH_TOP = '1;
  localparam logic [HASH_W-1:0] HASH_MSB = 32'h8000_0000;
  localparam logic [HASH_W-1:0] HASH_LSB = 32'h0000_0001;

  typedef enum int {
    PH_DIRECTED, PH_FILL, PH_CALM, PH_PRESSURE, PH_REUSE
  } phase_t;

  logic                clk;
  logic                rst_n               = 1'b0;
  logic                in_valid            = 1'b0;
  logic                in_kind             = KIND_CAND;
  logic [HASH_W-1:0]   in_candidate_hash   = '0;
  logic [RAND_W-1:0]   in_rand_fresh       = '0;
  logic [RAND_W-1:0]   in_rand_any         = '0;
  logic                out_ready           = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [HASH_W-1:0]   out_chosen_hash;
  logic [COUNT_W-1:0]  out_total_count;
  logic [COUNT_W-1:0]  out_available_count;

  int     mismatches;
  int     picks_pending;
  phase_t stim_phase   = PH_DIRECTED;
  bit     calm         = 1'b0;
  int     quiet_cycles = 0;

  logic [HASH_W-1:0] sent_pool [$];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  no_repeat_random_picker uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_candidate_hash   (in_candidate_hash),
    .in_rand_fresh       (in_rand_fresh),
    .in_rand_any         (in_rand_any),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_chosen_hash     (out_chosen_hash),
    .out_total_count     (out_total_count),
    .out_available_count (out_available_count)
  );

  npr_pick_checker #(
    .HISTORY_DEPTH (HISTORY_DEPTH_DEF)
  ) pick_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_candidate_hash   (in_candidate_hash),
    .in_rand_fresh       (in_rand_fresh),
    .in_rand_any         (in_rand_any),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_chosen_hash     (out_chosen_hash),
    .out_total_count     (out_total_count),
    .out_available_count (out_available_count),
    .mismatches          (mismatches),
    .picks_pending       (picks_pending)
  );

  // Offer one word, after a random gap unless idling is off, and hold it
  // until the block takes it.
  task automatic send_word(input logic kind, input logic [HASH_W-1:0] hash,
                           input logic [RAND_W-1:0] rf, input logic [RAND_W-1:0] ra);
    if (!calm) begin
      while ($urandom_range(99) < 22) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid          <= 1'b1;
    in_kind           <= kind;
    in_candidate_hash <= hash;
    in_rand_fresh     <= rf;
    in_rand_any       <= ra;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Random words lean toward small values so the samplers replace often.
  function automatic logic [RAND_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(8);
      default: return $urandom;
    endcase
  endfunction

  // Candidate hash: a few zeros, extremes and recently sent hashes in
  // proportion to reuse_pct, otherwise a new random hash.
  function automatic logic [HASH_W-1:0] pick_hash(int reuse_pct);
    int r;
    r = $urandom_range(99);
    if (r < 2) return '0;
    if (r < 2 + reuse_pct / 10) begin
      case ($urandom_range(2))
        0:       return HASH_TOP;
        1:       return HASH_MSB;
        default: return HASH_LSB;
      endcase
    end
    if (r < 2 + reuse_pct && sent_pool.size() > 0)
      return sent_pool[$urandom_range(sent_pool.size() - 1)];
    return $urandom;
  endfunction

  // Well-formed scans of random length, each closed by an end-of-scan word
  // whose payload is junk.
  task automatic run_scans(int words, int reuse_pct, int max_len);
    int sent;
    int len;
    int r;
    logic [HASH_W-1:0] h;
    sent = 0;
    while (sent < words) begin
      r = $urandom_range(99);
      len = (r < 5) ? 0 : (r < 80) ? $urandom_range(1, 2) : $urandom_range(3, max_len);
      repeat (len) begin
        h = pick_hash(reuse_pct);
        send_word(KIND_CAND, h, rand_word(), rand_word());
        sent_pool.push_back(h);
        if (sent_pool.size() > 64) void'(sent_pool.pop_front());
      end
      send_word(KIND_END, $urandom, $urandom, $urandom);
      sent += len + 1;
    end
  endtask

  // Receiver: random stalls, none while calm, and one long hold-off when
  // the pressure phase begins so that a second result backs up the input.
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && stim_phase == PH_PRESSURE) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 22);
    end
  end

  // Watchdog: too long without any word moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty scan: nothing found; the hash of an end word is ignored.
    send_word(KIND_END, HASH_TOP, '1, '1);
    // A zero hash is returned but never recorded, so it stays fresh.
    send_word(KIND_CAND, '0, '0, '0);
    send_word(KIND_END, '0, '0, '0);
    send_word(KIND_CAND, '0, '1, '1);
    send_word(KIND_END, HASH_LSB, '0, '0);
    // All-ones hash is recorded, then offered alone again: history is cleared.
    send_word(KIND_CAND, HASH_TOP, '1, '1);
    send_word(KIND_END, '0, '0, '0);
    send_word(KIND_CAND, HASH_TOP, '0, '0);
    send_word(KIND_END, '0, '0, '0);
    // Mixed scan: a repeated candidate, a recorded one, both samplers replacing.
    send_word(KIND_CAND, HASH_MSB, '0, 32'd5);
    send_word(KIND_CAND, HASH_LSB, 32'd1, 32'd2);
    send_word(KIND_CAND, HASH_TOP, 32'd9, 32'd3);
    send_word(KIND_CAND, HASH_LSB, 32'd3, 32'd7);
    send_word(KIND_END, '1, '1, '1);
    // One recorded and one fresh candidate: the fresh one wins.
    send_word(KIND_CAND, HASH_LSB, '0, '0);
    send_word(KIND_CAND, HASH_MSB, 32'd7, '1);
    send_word(KIND_END, '0, '0, '0);
    // Every candidate recorded: clear the history and pick among all.
    send_word(KIND_CAND, HASH_TOP, '1, '0);
    send_word(KIND_CAND, HASH_LSB, '0, 32'd1);
    send_word(KIND_CAND, HASH_MSB, '0, 32'd6);
    send_word(KIND_END, '0, '0, '0);

    // New random hashes and a few zeros: the history fills and then rolls over.
    stim_phase <= PH_FILL;
    run_scans(420, 0, 4);
    stim_phase <= PH_CALM;
    calm <= 1'b1;
    run_scans(150, 40, 6);
    calm <= 1'b0;
    stim_phase <= PH_PRESSURE;
    run_scans(40, 30, 4);
    // Mostly reused hashes: scans with nothing fresh clear the history.
    stim_phase <= PH_REUSE;
    run_scans(280, 85, 6);

    in_valid <= 1'b0;
    @(posedge clk);
    while (picks_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && picks_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
